// ----- hw/rtl/v3m_pkg.sv -----
package v3m_pkg;

    localparam int CW         = 32;
    localparam int FRAC       = 16;
    localparam int EPS_W      = 31;
    localparam int SUMSQ_W    = 2 * CW;
    localparam int SQRT_STEPS = CW;
    localparam int QUO_W      = FRAC + 1;
    localparam int DIVD_W     = CW + FRAC;
    localparam int LSQ_W      = SUMSQ_W - FRAC;
    localparam int EXT_W      = 2 * CW + 2;

    localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(66);

    typedef enum logic [3:0] {
        OP_ADD    = 4'd0,
        OP_SUB    = 4'd1,
        OP_NEG    = 4'd2,
        OP_SCALE  = 4'd3,
        OP_DOT    = 4'd4,
        OP_CROSS  = 4'd5,
        OP_LENSQ  = 4'd6,
        OP_LEN    = 4'd7,
        OP_NORM   = 4'd8,
        OP_ISZERO = 4'd9,
        OP_ISUNIT = 4'd10
    } t_op;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

    typedef struct packed {
        logic [3:0]              op;
        logic [CW-1:0]           rx;
        logic [CW-1:0]           ry;
        logic [CW-1:0]           rz;
        logic [CW-1:0]           rs;
        logic                    flag;
        logic [1:0]              status;
        logic [2:0][CW-1:0]      mag;
        logic [2:0]              neg;
    } t_carry;

    function automatic logic [CW:0] sat_cw(input logic signed [EXT_W-1:0] v);
        logic signed [EXT_W-1:0] hi;
        logic signed [EXT_W-1:0] lo;
        hi = $signed({{(CW+3){1'b0}}, {(CW-1){1'b1}}});
        lo = $signed({{(CW+3){1'b1}}, {(CW-1){1'b0}}});
        if (v > hi) begin
            return {1'b1, 1'b0, {(CW-1){1'b1}}};
        end else if (v < lo) begin
            return {1'b1, 1'b1, {(CW-1){1'b0}}};
        end else begin
            return {1'b0, v[CW-1:0]};
        end
    endfunction

    function automatic logic [CW-1:0] mag_cw(input logic [CW-1:0] v);
        return v[CW-1] ? CW'(~v + 1'b1) : v;
    endfunction

endpackage

// ----- hw/rtl/vec3_math_unit.sv -----
// A request passes through 52 register stages (2 front, 32 square root, 17 divide, 1 output)
// on its way from the edge that accepts it to a valid result.
// Throughput: one request per cycle; the whole pipeline holds while a result is stalled.
// Reset (synchronous, active low) empties the pipeline and sets epsilon to 66.
module vec3_math_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [v3m_pkg::EPS_W-1:0]         i_cfg_wdata,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [3:0]                        i_opcode,
    input  logic signed [v3m_pkg::CW-1:0]     i_a_x,
    input  logic signed [v3m_pkg::CW-1:0]     i_a_y,
    input  logic signed [v3m_pkg::CW-1:0]     i_a_z,
    input  logic signed [v3m_pkg::CW-1:0]     i_b_x,
    input  logic signed [v3m_pkg::CW-1:0]     i_b_y,
    input  logic signed [v3m_pkg::CW-1:0]     i_b_z,
    input  logic signed [v3m_pkg::CW-1:0]     i_scale_factor,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [v3m_pkg::CW-1:0]     o_r_x,
    output logic signed [v3m_pkg::CW-1:0]     o_r_y,
    output logic signed [v3m_pkg::CW-1:0]     o_r_z,
    output logic signed [v3m_pkg::CW-1:0]     o_r_scalar,
    output logic                              o_test_flag,
    output logic [1:0]                        o_status
);

    localparam int CW    = v3m_pkg::CW;
    localparam int FRAC  = v3m_pkg::FRAC;
    localparam int PW    = 2 * CW;
    localparam int XW    = v3m_pkg::EXT_W;
    localparam int LW    = v3m_pkg::LSQ_W;
    localparam int QW    = v3m_pkg::QUO_W;

    logic                        w_adv;
    logic [v3m_pkg::EPS_W-1:0]   r_eps;

    logic signed [CW-1:0]  w_a [3];
    logic signed [CW-1:0]  w_b [3];
    logic signed [CW-1:0]  w_ma [6];
    logic signed [CW-1:0]  w_mb [6];
    logic signed [CW:0]    w_va [3];
    logic [CW-1:0]         w_mag [3];

    logic                  r1_v;
    logic [3:0]            r1_op;
    logic signed [PW-1:0]  r1_p [6];
    logic [PW-1:0]         r1_sq [3];
    logic signed [CW:0]    r1_va [3];
    logic [CW-1:0]         r1_mag [3];
    logic [2:0]            r1_neg;

    logic [CW:0]           w_s_sc [3];
    logic [CW:0]           w_s_cr [3];
    logic [CW:0]           w_s_va [3];
    logic [CW:0]           w_s_dot;
    logic signed [XW-1:0]  w_dot;
    logic [PW-1:0]         w_sumsq;
    logic [LW-1:0]         w_lsq;
    logic [LW-1:0]         w_one;
    logic [LW-1:0]         w_diff;
    logic                  w_zero;
    v3m_pkg::t_carry       n_c;

    logic                  r2_v;
    v3m_pkg::t_carry       r2_c;
    logic [PW-1:0]         r2_sumsq;

    logic                  w_sq_v;
    logic [CW-1:0]         w_root;
    v3m_pkg::t_carry       w_sq_c;
    logic                  w_dv_v;
    logic [CW-1:0]         w_len;
    logic [2:0][QW-1:0]    w_quo;
    v3m_pkg::t_carry       w_dv_c;

    v3m_pkg::t_carry       n_o;
    logic                  r_ov;
    v3m_pkg::t_carry       r_o;

    assign w_adv   = !r_ov || !i_stall;
    assign o_stall = !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= v3m_pkg::EPS_RESET;
        end else if (i_cfg_we) begin
            r_eps <= i_cfg_wdata;
        end
    end

    always_comb begin
        w_a[0] = i_a_x;
        w_a[1] = i_a_y;
        w_a[2] = i_a_z;
        w_b[0] = i_b_x;
        w_b[1] = i_b_y;
        w_b[2] = i_b_z;
        for (int i = 0; i < 6; i++) begin
            w_ma[i] = '0;
            w_mb[i] = '0;
        end
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = v3m_pkg::mag_cw(w_a[i]);
        end
        case (i_opcode)
            v3m_pkg::OP_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    w_ma[i] = w_a[i];
                    w_mb[i] = i_scale_factor;
                end
            end
            v3m_pkg::OP_CROSS: begin
                w_ma[0] = w_a[1]; w_mb[0] = w_b[2];
                w_ma[1] = w_a[2]; w_mb[1] = w_b[0];
                w_ma[2] = w_a[0]; w_mb[2] = w_b[1];
                w_ma[3] = w_a[2]; w_mb[3] = w_b[1];
                w_ma[4] = w_a[0]; w_mb[4] = w_b[2];
                w_ma[5] = w_a[1]; w_mb[5] = w_b[0];
            end
            default: begin
                for (int i = 0; i < 3; i++) begin
                    w_ma[i] = w_a[i];
                    w_mb[i] = w_b[i];
                end
            end
        endcase
        for (int i = 0; i < 3; i++) begin
            case (i_opcode)
                v3m_pkg::OP_ADD: w_va[i] = {w_a[i][CW-1], w_a[i]} + {w_b[i][CW-1], w_b[i]};
                v3m_pkg::OP_SUB: w_va[i] = {w_a[i][CW-1], w_a[i]} - {w_b[i][CW-1], w_b[i]};
                v3m_pkg::OP_NEG: w_va[i] = -{w_a[i][CW-1], w_a[i]};
                default:         w_va[i] = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_adv) begin
            r1_v <= i_valid;
        end
        if (w_adv) begin
            r1_op <= i_opcode;
            for (int i = 0; i < 6; i++) begin
                r1_p[i] <= w_ma[i] * w_mb[i];
            end
            for (int i = 0; i < 3; i++) begin
                r1_sq[i]  <= w_mag[i] * w_mag[i];
                r1_va[i]  <= w_va[i];
                r1_mag[i] <= w_mag[i];
                r1_neg[i] <= w_a[i][CW-1];
            end
        end
    end

    always_comb begin
        w_dot = $signed({{2{r1_p[0][PW-1]}}, r1_p[0]})
              + $signed({{2{r1_p[1][PW-1]}}, r1_p[1]})
              + $signed({{2{r1_p[2][PW-1]}}, r1_p[2]});
        w_s_dot = v3m_pkg::sat_cw(w_dot >>> FRAC);
        for (int i = 0; i < 3; i++) begin
            w_s_sc[i] = v3m_pkg::sat_cw($signed({{2{r1_p[i][PW-1]}}, r1_p[i]}) >>> FRAC);
            w_s_cr[i] = v3m_pkg::sat_cw(($signed({{2{r1_p[i][PW-1]}}, r1_p[i]})
                      - $signed({{2{r1_p[i+3][PW-1]}}, r1_p[i+3]})) >>> FRAC);
            w_s_va[i] = v3m_pkg::sat_cw($signed({{(XW-CW-1){r1_va[i][CW]}}, r1_va[i]}));
        end
        w_sumsq = r1_sq[0] + r1_sq[1] + r1_sq[2];
        w_lsq   = w_sumsq[PW-1:FRAC];
        w_one   = LW'(1) << FRAC;
        w_diff  = (w_lsq > w_one) ? (w_lsq - w_one) : (w_one - w_lsq);
        w_zero  = (r1_mag[0] < {1'b0, r_eps}) && (r1_mag[1] < {1'b0, r_eps})
               && (r1_mag[2] < {1'b0, r_eps});

        n_c        = '0;
        n_c.op     = r1_op;
        n_c.neg    = r1_neg;
        for (int i = 0; i < 3; i++) begin
            n_c.mag[i] = r1_mag[i];
        end
        case (r1_op)
            v3m_pkg::OP_ADD, v3m_pkg::OP_SUB, v3m_pkg::OP_NEG: begin
                n_c.rx = w_s_va[0][CW-1:0];
                n_c.ry = w_s_va[1][CW-1:0];
                n_c.rz = w_s_va[2][CW-1:0];
                if (w_s_va[0][CW] || w_s_va[1][CW] || w_s_va[2][CW]) begin
                    n_c.status = v3m_pkg::ST_SAT;
                end
            end
            v3m_pkg::OP_SCALE: begin
                n_c.rx = w_s_sc[0][CW-1:0];
                n_c.ry = w_s_sc[1][CW-1:0];
                n_c.rz = w_s_sc[2][CW-1:0];
                if (w_s_sc[0][CW] || w_s_sc[1][CW] || w_s_sc[2][CW]) begin
                    n_c.status = v3m_pkg::ST_SAT;
                end
            end
            v3m_pkg::OP_CROSS: begin
                n_c.rx = w_s_cr[0][CW-1:0];
                n_c.ry = w_s_cr[1][CW-1:0];
                n_c.rz = w_s_cr[2][CW-1:0];
                if (w_s_cr[0][CW] || w_s_cr[1][CW] || w_s_cr[2][CW]) begin
                    n_c.status = v3m_pkg::ST_SAT;
                end
            end
            v3m_pkg::OP_DOT: begin
                n_c.rs = w_s_dot[CW-1:0];
                if (w_s_dot[CW]) begin
                    n_c.status = v3m_pkg::ST_SAT;
                end
            end
            v3m_pkg::OP_LENSQ: begin
                if (w_lsq > LW'({(CW-1){1'b1}})) begin
                    n_c.rs     = {1'b0, {(CW-1){1'b1}}};
                    n_c.status = v3m_pkg::ST_SAT;
                end else begin
                    n_c.rs = w_lsq[CW-1:0];
                end
            end
            v3m_pkg::OP_ISZERO: n_c.flag = w_zero;
            v3m_pkg::OP_ISUNIT: n_c.flag = (w_diff < LW'(r_eps));
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_adv) begin
            r2_v <= r1_v;
        end
        if (w_adv) begin
            r2_c     <= n_c;
            r2_sumsq <= w_sumsq;
        end
    end

    v3m_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r2_v),
        .i_n     (r2_sumsq),
        .i_carry (r2_c),
        .o_valid (w_sq_v),
        .o_root  (w_root),
        .o_carry (w_sq_c)
    );

    v3m_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_sq_v),
        .i_len   (w_root),
        .i_carry (w_sq_c),
        .o_valid (w_dv_v),
        .o_len   (w_len),
        .o_quo   (w_quo),
        .o_carry (w_dv_c)
    );

    always_comb begin
        n_o = w_dv_c;
        case (w_dv_c.op)
            v3m_pkg::OP_LEN: begin
                if (w_len[CW-1]) begin
                    n_o.rs     = {1'b0, {(CW-1){1'b1}}};
                    n_o.status = v3m_pkg::ST_SAT;
                end else begin
                    n_o.rs = w_len;
                end
            end
            v3m_pkg::OP_NORM: begin
                if (w_len == '0) begin
                    n_o.status = v3m_pkg::ST_DIVZ;
                end else begin
                    n_o.rx = w_dv_c.neg[0] ? (CW'(0) - CW'(w_quo[0])) : CW'(w_quo[0]);
                    n_o.ry = w_dv_c.neg[1] ? (CW'(0) - CW'(w_quo[1])) : CW'(w_quo[1]);
                    n_o.rz = w_dv_c.neg[2] ? (CW'(0) - CW'(w_quo[2])) : CW'(w_quo[2]);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_ov <= w_dv_v;
        end
        if (w_adv) begin
            r_o <= n_o;
        end
    end

    assign o_valid     = r_ov;
    assign o_r_x       = r_o.rx;
    assign o_r_y       = r_o.ry;
    assign o_r_z       = r_o.rz;
    assign o_r_scalar  = r_o.rs;
    assign o_test_flag = r_o.flag;
    assign o_status    = r_o.status;

endmodule

// ----- hw/rtl/v3m_isqrt.sv -----
module v3m_isqrt (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [v3m_pkg::SUMSQ_W-1:0]         i_n,
    input  v3m_pkg::t_carry                     i_carry,
    output logic                                o_valid,
    output logic [v3m_pkg::CW-1:0]              o_root,
    output v3m_pkg::t_carry                     o_carry
);

    localparam int STEPS = v3m_pkg::SQRT_STEPS;
    localparam int NW    = v3m_pkg::SUMSQ_W;
    localparam int RW    = v3m_pkg::CW;
    localparam int REMW  = RW + 2;

    logic                r_v     [STEPS];
    logic [NW-1:0]       r_n     [STEPS];
    logic [REMW-1:0]     r_rem   [STEPS];
    logic [RW-1:0]       r_root  [STEPS];
    v3m_pkg::t_carry     r_c     [STEPS];

    for (genvar g = 0; g < STEPS; g++) begin : g_st
        logic              w_v_in;
        logic [NW-1:0]     w_n_in;
        logic [REMW-1:0]   w_rem_in;
        logic [RW-1:0]     w_root_in;
        v3m_pkg::t_carry   w_c_in;
        logic [REMW+1:0]   w_rem;
        logic [REMW+1:0]   w_trial;
        logic [REMW-1:0]   n_rem;
        logic [RW-1:0]     n_root;

        if (g == 0) begin : g_first
            assign w_v_in    = i_valid;
            assign w_n_in    = i_n;
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_c_in    = i_carry;
        end else begin : g_next
            assign w_v_in    = r_v[g-1];
            assign w_n_in    = r_n[g-1];
            assign w_rem_in  = r_rem[g-1];
            assign w_root_in = r_root[g-1];
            assign w_c_in    = r_c[g-1];
        end

        always_comb begin
            w_rem   = {w_rem_in, w_n_in[NW-1:NW-2]};
            w_trial = {2'b00, w_root_in, 2'b01};
            if (w_rem >= w_trial) begin
                n_rem  = REMW'(w_rem - w_trial);
                n_root = {w_root_in[RW-2:0], 1'b1};
            end else begin
                n_rem  = REMW'(w_rem);
                n_root = {w_root_in[RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= w_v_in;
            end
            if (i_en) begin
                r_n[g]    <= {w_n_in[NW-3:0], 2'b00};
                r_rem[g]  <= n_rem;
                r_root[g] <= n_root;
                r_c[g]    <= w_c_in;
            end
        end
    end

    assign o_valid = r_v[STEPS-1];
    assign o_root  = r_root[STEPS-1];
    assign o_carry = r_c[STEPS-1];

endmodule

// ----- hw/rtl/v3m_div.sv -----
module v3m_div (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  logic [v3m_pkg::CW-1:0]                i_len,
    input  v3m_pkg::t_carry                       i_carry,
    output logic                                  o_valid,
    output logic [v3m_pkg::CW-1:0]                o_len,
    output logic [2:0][v3m_pkg::QUO_W-1:0]        o_quo,
    output v3m_pkg::t_carry                       o_carry
);

    localparam int STEPS = v3m_pkg::QUO_W;
    localparam int DW    = v3m_pkg::DIVD_W;
    localparam int QW    = v3m_pkg::QUO_W;
    localparam int FR    = v3m_pkg::FRAC;

    logic                     r_v    [STEPS];
    logic [v3m_pkg::CW-1:0]   r_len  [STEPS];
    logic [2:0][DW-1:0]       r_rem  [STEPS];
    logic [2:0][QW-1:0]       r_quo  [STEPS];
    v3m_pkg::t_carry          r_c    [STEPS];

    for (genvar g = 0; g < STEPS; g++) begin : g_st
        logic                     w_v_in;
        logic [v3m_pkg::CW-1:0]   w_len_in;
        logic [2:0][DW-1:0]       w_rem_in;
        logic [2:0][QW-1:0]       w_quo_in;
        v3m_pkg::t_carry          w_c_in;
        logic [DW:0]              w_div;
        logic [2:0][DW-1:0]       n_rem;
        logic [2:0][QW-1:0]       n_quo;

        if (g == 0) begin : g_first
            assign w_v_in   = i_valid;
            assign w_len_in = i_len;
            assign w_quo_in = '0;
            assign w_c_in   = i_carry;
            for (genvar l = 0; l < 3; l++) begin : g_lane
                assign w_rem_in[l] = {i_carry.mag[l], {FR{1'b0}}};
            end
        end else begin : g_next
            assign w_v_in   = r_v[g-1];
            assign w_len_in = r_len[g-1];
            assign w_rem_in = r_rem[g-1];
            assign w_quo_in = r_quo[g-1];
            assign w_c_in   = r_c[g-1];
        end

        always_comb begin
            w_div = (DW+1)'(w_len_in) << (STEPS - 1 - g);
            for (int l = 0; l < 3; l++) begin
                if ({1'b0, w_rem_in[l]} >= w_div) begin
                    n_rem[l] = w_rem_in[l] - w_div[DW-1:0];
                    n_quo[l] = {w_quo_in[l][QW-2:0], 1'b1};
                end else begin
                    n_rem[l] = w_rem_in[l];
                    n_quo[l] = {w_quo_in[l][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= w_v_in;
            end
            if (i_en) begin
                r_len[g] <= w_len_in;
                r_rem[g] <= n_rem;
                r_quo[g] <= n_quo;
                r_c[g]   <= w_c_in;
            end
        end
    end

    assign o_valid = r_v[STEPS-1];
    assign o_len   = r_len[STEPS-1];
    assign o_quo   = r_quo[STEPS-1];
    assign o_carry = r_c[STEPS-1];

endmodule

// ----- hw/rtl/v3m_checker.sv -----
module v3m_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [v3m_pkg::CW-1:0]        o_r_x,
    input logic [v3m_pkg::CW-1:0]        o_r_y,
    input logic [v3m_pkg::CW-1:0]        o_r_z,
    input logic [v3m_pkg::CW-1:0]        o_r_scalar,
    input logic                          o_test_flag,
    input logic [1:0]                    o_status
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_r_x) && $stable(o_r_scalar)
                               && $stable(o_status))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status == v3m_pkg::ST_OK || o_status == v3m_pkg::ST_SAT
                    || o_status == v3m_pkg::ST_DIVZ)
        else $error("undefined status");

    a_divz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == v3m_pkg::ST_DIVZ |->
            o_r_x == '0 && o_r_y == '0 && o_r_z == '0 && o_r_scalar == '0)
        else $error("zero-length normalize gave a nonzero result");

    a_flag_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_test_flag |->
            o_r_x == '0 && o_r_y == '0 && o_r_z == '0 && o_r_scalar == '0
            && o_status == v3m_pkg::ST_OK)
        else $error("test result carries other data");

endmodule

bind vec3_math_unit v3m_checker u_v3m_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_r_x       (o_r_x),
    .o_r_y       (o_r_y),
    .o_r_z       (o_r_z),
    .o_r_scalar  (o_r_scalar),
    .o_test_flag (o_test_flag),
    .o_status    (o_status)
);
